@@ hw/rtl/lsst_pkg.sv @@
// Shared types, constants and helpers for the line sensor scan block.
package lsst_pkg;

  localparam int NUM_POS   = 8;
  localparam int LEVEL_W   = 12;
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = 16;
  localparam int SCNT_W    = 4;
  localparam int POS_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // fixed-point reciprocal shift, exact for 16-bit sums and divisors up to 16
  localparam int RECIP_SHIFT = 21;

  localparam int DEF_SENSORS       = 8;
  localparam int DEF_SAMPLES       = 8;
  localparam int DEF_LINE_IS_DARK  = 1;
  localparam int DEF_REVERSE_ORDER = 0;

  typedef logic [NUM_POS-1:0][LEVEL_W-1:0] level_vec_t;

  // one event handed from the accumulator to the finish stage
  typedef struct packed {
    logic             fail;
    logic             last;
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] sum;
  } lsst_event_t;

  function automatic logic [COUNT_W-1:0] pop_count(input logic [NUM_POS-1:0] m);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_POS; i++) begin
      n = n + COUNT_W'(m[i]);
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/lsst_regs.sv @@
// APB threshold register file.
module lsst_regs
  import lsst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output level_vec_t            thr
);

  level_vec_t       thr_r;
  level_vec_t       thr_nxt;
  logic [POS_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx    = cfg_paddr[APB_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(APB_DATA_W-LEVEL_W){1'b0}}, thr_r[reg_idx]};
  assign thr        = thr_r;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      thr_nxt[reg_idx] = cfg_pwdata[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else begin
      thr_r <= thr_nxt;
    end
  end

endmodule

@@ hw/rtl/lsst_accum.sv @@
// Sample accumulator and channel sequencer; emits one event per finished channel or failure.
module lsst_accum
  import lsst_pkg::*;
#(
  parameter int SENSORS       = DEF_SENSORS,
  parameter int SAMPLES       = DEF_SAMPLES,
  parameter int REVERSE_ORDER = DEF_REVERSE_ORDER
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [SAMPLE_W-1:0] in_adc_sample,
  input  logic                in_conversion_failed,
  output logic                ev_valid,
  input  logic                ev_ready,
  output lsst_event_t         ev
);

  localparam logic [SCNT_W-1:0] LAST_SAMPLE = SCNT_W'(SAMPLES - 1);
  localparam logic [POS_W-1:0]  LAST_CH     = POS_W'(SENSORS - 1);

  logic [POS_W-1:0]  ch_r, ch_nxt;
  logic [SCNT_W-1:0] scnt_r, scnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              ev_valid_r, ev_valid_nxt;
  lsst_event_t       ev_r, ev_nxt;

  logic              accept;
  logic [SUM_W-1:0]  sum_add;
  logic [POS_W-1:0]  pos;

  assign in_ready = !ev_valid_r || ev_ready;
  assign accept   = in_valid && in_ready;
  assign sum_add  = sum_r + {{(SUM_W-SAMPLE_W){1'b0}}, in_adc_sample};
  assign pos      = (REVERSE_ORDER != 0) ? (LAST_CH - ch_r) : ch_r;
  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

  always_comb begin
    ch_nxt       = ch_r;
    scnt_nxt     = scnt_r;
    sum_nxt      = sum_r;
    ev_valid_nxt = ev_valid_r && !ev_ready;
    ev_nxt       = ev_r;
    if (accept) begin
      priority if (in_conversion_failed) begin
        ch_nxt       = '0;
        scnt_nxt     = '0;
        sum_nxt      = '0;
        ev_valid_nxt = 1'b1;
        ev_nxt       = '{fail: 1'b1, last: 1'b0, pos: '0, sum: '0};
      end else if (scnt_r == LAST_SAMPLE) begin
        scnt_nxt     = '0;
        sum_nxt      = '0;
        ch_nxt       = (ch_r == LAST_CH) ? '0 : ch_r + 1'b1;
        ev_valid_nxt = 1'b1;
        ev_nxt       = '{fail: 1'b0, last: (ch_r == LAST_CH), pos: pos, sum: sum_add};
      end else begin
        scnt_nxt = scnt_r + 1'b1;
        sum_nxt  = sum_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r       <= '0;
      scnt_r     <= '0;
      sum_r      <= '0;
      ev_valid_r <= 1'b0;
    end else begin
      ch_r       <= ch_nxt;
      scnt_r     <= scnt_nxt;
      sum_r      <= sum_nxt;
      ev_valid_r <= ev_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

endmodule

@@ hw/rtl/lsst_finish.sv @@
// Averaging, threshold compare, level store, line mask and result register.
module lsst_finish
  import lsst_pkg::*;
#(
  parameter int SAMPLES      = DEF_SAMPLES,
  parameter int LINE_IS_DARK = DEF_LINE_IS_DARK
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  lsst_event_t        ev,
  input  level_vec_t         thr,
  output logic               out_valid,
  input  logic               out_ready,
  output level_vec_t         out_levels,
  output logic [NUM_POS-1:0] out_mask,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_ok
);

  // sum / SAMPLES as sum * ceil(2^S / SAMPLES) >> S
  localparam int                   RECIP_INT = ((1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam logic [RECIP_SHIFT:0] RECIP     = RECIP_INT[RECIP_SHIFT:0];

  level_vec_t         store_r, store_nxt;
  logic [NUM_POS-1:0] mask_r, mask_nxt;
  logic               out_valid_r, out_valid_nxt;
  level_vec_t         out_levels_r, out_levels_nxt;
  logic [NUM_POS-1:0] out_mask_r, out_mask_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_ok_r, out_ok_nxt;

  logic [SUM_W+RECIP_SHIFT:0] prod;
  logic [LEVEL_W-1:0]         level_new;
  logic [LEVEL_W-1:0]         thr_sel;
  logic                       hit;
  level_vec_t                 levels_upd;
  logic [NUM_POS-1:0]         mask_upd;
  logic                       needs_out;
  logic                       go;

  assign prod      = {{(RECIP_SHIFT+1){1'b0}}, ev.sum} * {{SUM_W{1'b0}}, RECIP};
  assign level_new = prod[RECIP_SHIFT +: LEVEL_W];
  assign thr_sel   = thr[ev.pos];
  assign hit       = (LINE_IS_DARK != 0) ? (level_new < thr_sel) : (level_new > thr_sel);
  assign mask_upd  = mask_r | (NUM_POS'(hit) << ev.pos);

  always_comb begin
    levels_upd         = store_r;
    levels_upd[ev.pos] = level_new;
  end

  assign needs_out = ev.fail || ev.last;
  assign ev_ready  = !needs_out || !out_valid_r || out_ready;
  assign go        = ev_valid && ev_ready;

  always_comb begin
    store_nxt      = store_r;
    mask_nxt       = mask_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_levels_nxt = out_levels_r;
    out_mask_nxt   = out_mask_r;
    out_count_nxt  = out_count_r;
    out_ok_nxt     = out_ok_r;
    if (go) begin
      priority if (ev.fail) begin
        // aborted frame: report levels as stored, no line
        mask_nxt       = '0;
        out_valid_nxt  = 1'b1;
        out_levels_nxt = store_r;
        out_mask_nxt   = '0;
        out_count_nxt  = '0;
        out_ok_nxt     = 1'b0;
      end else if (ev.last) begin
        store_nxt      = levels_upd;
        mask_nxt       = '0;
        out_valid_nxt  = 1'b1;
        out_levels_nxt = levels_upd;
        out_mask_nxt   = mask_upd;
        out_count_nxt  = pop_count(mask_upd);
        out_ok_nxt     = 1'b1;
      end else begin
        store_nxt = levels_upd;
        mask_nxt  = mask_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      store_r     <= store_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_levels_r <= out_levels_nxt;
    out_mask_r   <= out_mask_nxt;
    out_count_r  <= out_count_nxt;
    out_ok_r     <= out_ok_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_levels = out_levels_r;
  assign out_mask   = out_mask_r;
  assign out_count  = out_count_r;
  assign out_ok     = out_ok_r;

endmodule

@@ hw/rtl/line_sensor_scan_threshold.sv @@
// Line sensor scan: per-channel averaging, thresholding and line bitmap.
// Result path: the frame's last request is registered as an event, which then loads the result register.
// Throughput: one request per cycle; in_ready drops only while a result waits and the
// next event would produce another one.
// Reset: rst_n synchronous, active low; clears counters, sum, levels, mask and thresholds.
module line_sensor_scan_threshold
  import lsst_pkg::*;
#(
  parameter int SENSORS       = DEF_SENSORS,
  parameter int SAMPLES       = DEF_SAMPLES,
  parameter int LINE_IS_DARK  = DEF_LINE_IS_DARK,
  parameter int REVERSE_ORDER = DEF_REVERSE_ORDER
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_adc_sample,
  input  logic                  in_conversion_failed,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_level_0,
  output logic [LEVEL_W-1:0]    out_level_1,
  output logic [LEVEL_W-1:0]    out_level_2,
  output logic [LEVEL_W-1:0]    out_level_3,
  output logic [LEVEL_W-1:0]    out_level_4,
  output logic [LEVEL_W-1:0]    out_level_5,
  output logic [LEVEL_W-1:0]    out_level_6,
  output logic [LEVEL_W-1:0]    out_level_7,
  output logic [NUM_POS-1:0]    out_line_mask,
  output logic [COUNT_W-1:0]    out_line_count,
  output logic                  out_frame_ok,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  level_vec_t  thr;
  level_vec_t  levels;
  logic        ev_valid;
  logic        ev_ready;
  lsst_event_t ev;

  lsst_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .thr         (thr)
  );

  lsst_accum #(
    .SENSORS       (SENSORS),
    .SAMPLES       (SAMPLES),
    .REVERSE_ORDER (REVERSE_ORDER)
  ) u_accum (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_adc_sample        (in_adc_sample),
    .in_conversion_failed (in_conversion_failed),
    .ev_valid             (ev_valid),
    .ev_ready             (ev_ready),
    .ev                   (ev)
  );

  lsst_finish #(
    .SAMPLES      (SAMPLES),
    .LINE_IS_DARK (LINE_IS_DARK)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .ev         (ev),
    .thr        (thr),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_levels (levels),
    .out_mask   (out_line_mask),
    .out_count  (out_line_count),
    .out_ok     (out_frame_ok)
  );

  assign out_level_0 = levels[0];
  assign out_level_1 = levels[1];
  assign out_level_2 = levels[2];
  assign out_level_3 = levels[3];
  assign out_level_4 = levels[4];
  assign out_level_5 = levels[5];
  assign out_level_6 = levels[6];
  assign out_level_7 = levels[7];

endmodule

@@ hw/rtl/lsst_checker.sv @@
// Port-level checker for the line sensor scan block, bound to the top level.
module lsst_checker
  import lsst_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_W-1:0]    out_level_0,
  input logic [LEVEL_W-1:0]    out_level_1,
  input logic [LEVEL_W-1:0]    out_level_2,
  input logic [LEVEL_W-1:0]    out_level_3,
  input logic [LEVEL_W-1:0]    out_level_4,
  input logic [LEVEL_W-1:0]    out_level_5,
  input logic [LEVEL_W-1:0]    out_level_6,
  input logic [LEVEL_W-1:0]    out_level_7,
  input logic [NUM_POS-1:0]    out_line_mask,
  input logic [COUNT_W-1:0]    out_line_count,
  input logic                  out_frame_ok,
  input logic                  cfg_pready
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_mask) &&
      $stable(out_line_count) && $stable(out_frame_ok) && $stable(out_level_0) &&
      $stable(out_level_1) && $stable(out_level_2) && $stable(out_level_3) &&
      $stable(out_level_4) && $stable(out_level_5) && $stable(out_level_6) &&
      $stable(out_level_7))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_count == COUNT_W'($countones(out_line_mask)))
    else $error("line count does not match mask");

  a_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_ok |-> out_line_mask == '0 && out_line_count == '0)
    else $error("aborted frame reports a line");

  // with no result waiting nothing can hold off a request
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with no result waiting");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind line_sensor_scan_threshold lsst_checker u_lsst_checker (.*);
